// ===== design/world_to_screen_projection_assert.svh =====
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define WTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wtsp_pkg.sv =====
package wtsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 14;
    localparam int DIV_STEPS = 32;
    // Product of the clip x or y magnitude and the half screen size in raw units.
    localparam int NUM_W     = 61;

    localparam logic signed [COORD_W-1:0] NEAR_RAW =
        COORD_W'(((1 << FRAC_BITS) + 999) / 1000);
    localparam logic signed [17:0] BEHIND_SCALE = 18'sd100000;

    localparam logic [2:0] CFG_ROW0_C01 = 3'd0;
    localparam logic [2:0] CFG_ROW0_C23 = 3'd1;
    localparam logic [2:0] CFG_ROW1_C01 = 3'd2;
    localparam logic [2:0] CFG_ROW1_C23 = 3'd3;
    localparam logic [2:0] CFG_ROW3_C01 = 3'd4;
    localparam logic [2:0] CFG_ROW3_C23 = 3'd5;
    localparam logic [2:0] CFG_WIDTH    = 3'd6;
    localparam logic [2:0] CFG_HEIGHT   = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      visible;
    } screen_t;

    // State carried through the divider stages for both axes.
    typedef struct packed {
        logic                      vis;
        logic [COORD_W-2:0]        w;
        logic signed [COORD_W-1:0] sx_behind;
        logic signed [COORD_W-1:0] sy_behind;
        logic                      neg_x;
        logic                      neg_y;
        logic                      ovf_x;
        logic                      ovf_y;
        logic [31:0]               rem_x;
        logic [31:0]               quo_x;
        logic [31:0]               rem_y;
        logic [31:0]               quo_y;
    } div_t;

endpackage

// ===== design/world_to_screen_projection.sv =====
// Perspective projection of world points to screen pixels. One point is accepted
// per cycle while the output does not stall. Most of the pipeline is the restoring
// divider, which resolves one quotient bit of x/w and y/w per stage over 32 stages,
// after five stages of matrix products, row sums, clip saturation, scaling and
// divider seeding. A stalled output holds each stage that is full; empty stages
// still take new data. The user writes matrix rows 0, 1 and 3 and the screen size
// through the configuration port only while idle; the block does not enforce this.
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  wtsp_pkg::point_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output wtsp_pkg::screen_t out_data
);
    import wtsp_pkg::*;

    localparam int NST   = 5 + DIV_STEPS + 1;
    localparam int ST_FIN = NST - 1;

    logic [63:0]         mat_reg [6];
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;

    logic [NST-1:0]      vld_reg;
    logic [NST:0]        en;

    logic signed [63:0]  prod_reg [3][3];
    logic signed [31:0]  m3_reg [3];
    logic signed [65:0]  acc_reg [3];
    logic signed [COORD_W-1:0] clip_reg [3];
    logic                vis_reg;
    logic [COORD_W-2:0]  w_reg;
    logic signed [49:0]  bx_reg;
    logic signed [49:0]  by_reg;
    logic [NUM_W-1:0]    nx_reg;
    logic [NUM_W-1:0]    ny_reg;
    logic                negx_reg;
    logic                negy_reg;
    div_t                div_reg [DIV_STEPS+1];
    screen_t             out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mat_reg[i] <= '0;
            end
            width_reg  <= SIZE_W'(1920);
            height_reg <= SIZE_W'(1080);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROW0_C01, CFG_ROW0_C23, CFG_ROW1_C01,
                CFG_ROW1_C23, CFG_ROW3_C01, CFG_ROW3_C23:
                    mat_reg[cfg_index] <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[ST_FIN];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: the nine matrix products.
    logic signed [31:0] pt [3];
    logic signed [31:0] ment [3][4];

    always_comb
    begin
        pt[0] = in_data.point_x;
        pt[1] = in_data.point_y;
        pt[2] = in_data.point_z;
        for (int r = 0; r < 3; r++)
        begin
            ment[r][0] = mat_reg[2*r][31:0];
            ment[r][1] = mat_reg[2*r][63:32];
            ment[r][2] = mat_reg[2*r+1][31:0];
            ment[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[r][j] <= ment[r][j] * pt[j];
                end
                m3_reg[r] <= ment[r][3];
            end
        end
    end

    // Stage 1: row sums, with the fourth column scaled by one.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc_reg[r] <= {{2{prod_reg[r][0][63]}}, prod_reg[r][0]}
                            + {{2{prod_reg[r][1][63]}}, prod_reg[r][1]}
                            + {{2{prod_reg[r][2][63]}}, prod_reg[r][2]}
                            + {{18{m3_reg[r][31]}}, m3_reg[r], 16'b0};
            end
        end
    end

    // Stage 2: drop the fraction and saturate to the coordinate width.
    logic signed [49:0] sh [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sh[r] = acc_reg[r][65:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (sh[r][49:31] == {19{sh[r][49]}})
                begin
                    clip_reg[r] <= sh[r][31:0];
                end
                else
                begin
                    clip_reg[r] <= sh[r][49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                end
            end
        end
    end

    // Stage 3: near test, behind scaling and the division numerators.
    logic [31:0] magx;
    logic [31:0] magy;

    always_comb
    begin
        magx = clip_reg[0][31] ? 32'(-clip_reg[0]) : clip_reg[0];
        magy = clip_reg[1][31] ? 32'(-clip_reg[1]) : clip_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            vis_reg  <= clip_reg[2] >= NEAR_RAW;
            w_reg    <= clip_reg[2][30:0];
            bx_reg   <= 50'(clip_reg[0]) * 50'(BEHIND_SCALE);
            by_reg   <= 50'(clip_reg[1]) * 50'(BEHIND_SCALE);
            nx_reg   <= NUM_W'(magx) * NUM_W'({width_reg, 15'b0});
            ny_reg   <= NUM_W'(magy) * NUM_W'({height_reg, 15'b0});
            negx_reg <= clip_reg[0][31];
            negy_reg <= clip_reg[1][31];
        end
    end

    // Stage 4: saturate the behind values and seed the dividers. A quotient
    // of 2^32 or more saturates the pixel value anyway, so only the low 32
    // quotient bits are resolved and the upper part becomes a flag.
    logic [28:0] hix;
    logic [28:0] hiy;

    assign hix = nx_reg[60:32];
    assign hiy = ny_reg[60:32];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            div_reg[0].vis   <= vis_reg;
            div_reg[0].w     <= w_reg;
            div_reg[0].sx_behind <= (bx_reg[49:31] == {19{bx_reg[49]}}) ? bx_reg[31:0]
                : (bx_reg[49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
            div_reg[0].sy_behind <= (by_reg[49:31] == {19{by_reg[49]}}) ? by_reg[31:0]
                : (by_reg[49] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
            div_reg[0].neg_x <= negx_reg;
            div_reg[0].neg_y <= negy_reg;
            div_reg[0].ovf_x <= 31'(hix) >= w_reg;
            div_reg[0].ovf_y <= 31'(hiy) >= w_reg;
            div_reg[0].rem_x <= 32'(hix);
            div_reg[0].quo_x <= nx_reg[31:0];
            div_reg[0].rem_y <= 32'(hiy);
            div_reg[0].quo_y <= ny_reg[31:0];
        end
    end

    // Divider: each stage brings down one numerator bit and shifts in one
    // quotient bit where that numerator bit leaves.
    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        logic [32:0] tx;
        logic [32:0] ty;
        logic        gex;
        logic        gey;
        div_t        nxt;

        always_comb
        begin
            tx  = {div_reg[s].rem_x, div_reg[s].quo_x[31]};
            ty  = {div_reg[s].rem_y, div_reg[s].quo_y[31]};
            gex = tx >= 33'(div_reg[s].w);
            gey = ty >= 33'(div_reg[s].w);
            nxt = div_reg[s];
            nxt.rem_x = gex ? 32'(tx - 33'(div_reg[s].w)) : tx[31:0];
            nxt.rem_y = gey ? 32'(ty - 33'(div_reg[s].w)) : ty[31:0];
            nxt.quo_x = {div_reg[s].quo_x[30:0], gex};
            nxt.quo_y = {div_reg[s].quo_y[30:0], gey};
        end

        always_ff @(posedge clk)
        begin
            if (en[5+s])
            begin
                div_reg[s+1] <= nxt;
            end
        end
    end

    // Final stage: offset from the screen center and saturate, or pass the behind values.
    div_t               dl;
    logic [32:0]        qx;
    logic [32:0]        qy;
    logic signed [34:0] sqx;
    logic signed [34:0] sqy;
    logic signed [34:0] sumx;
    logic signed [34:0] sumy;
    screen_t            res;

    always_comb
    begin
        dl   = div_reg[DIV_STEPS];
        qx   = dl.ovf_x ? {1'b1, 32'b0} : {1'b0, dl.quo_x};
        qy   = dl.ovf_y ? {1'b1, 32'b0} : {1'b0, dl.quo_y};
        sqx  = dl.neg_x ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
        sqy  = dl.neg_y ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
        sumx = $signed({6'b0, width_reg, 15'b0}) + sqx;
        sumy = $signed({6'b0, height_reg, 15'b0}) - sqy;
        res.visible = dl.vis;
        if (dl.vis)
        begin
            res.screen_x = (sumx[34:31] == {4{sumx[34]}}) ? sumx[31:0]
                : (sumx[34] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
            res.screen_y = (sumy[34:31] == {4{sumy[34]}}) ? sumy[31:0]
                : (sumy[34] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}});
        end
        else
        begin
            res.screen_x = dl.sx_behind;
            res.screen_y = dl.sy_behind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_FIN])
        begin
            out_reg <= res;
        end
    end

    `WTS_ASSERT_NEXT(a_clip_hold, vld_reg[2] && !en[3],
        vld_reg[2] && $stable(clip_reg[2]), "clip stage changed while stalled")
    `WTS_ASSERT_IMPL(a_vis_w_pos, vld_reg[4] && vis_reg,
        w_reg != '0, "visible point with zero w")
    `WTS_ASSERT_IMPL(a_div_rem, vld_reg[NST-2] && dl.vis && !dl.ovf_x,
        dl.rem_x < 32'(dl.w), "divider remainder not below w")
    `WTS_ASSERT_NEXT(a_take, in_valid && in_ready, vld_reg[0],
        "transfer did not enter the pipeline")

endmodule
